// ===== src/rfof_pkg.sv =====
// Package for the register field override filter.
// Holds the effect table, widths and codes shared by the core and its checker.
package rfof_pkg;

  localparam int NUM_EFFECTS = 32;
  localparam int REG_WIDTH   = 16;
  localparam int EFF_IDX_W   = $clog2(NUM_EFFECTS);
  localparam int ADJ_W       = REG_WIDTH + 1;
  localparam int SUM_W       = REG_WIDTH + 2;
  localparam int SHIFT_W     = 4;
  localparam int CFG_IDX_W   = 2;

  typedef logic [REG_WIDTH-1:0] reg_word_t;

  typedef enum logic {
    OP_SET       = 1'b0,
    OP_INTERCEPT = 1'b1
  } op_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGISTER_HOOK = 2'd0,
    CFG_DEFAULT_BASE  = 2'd1,
    CFG_NEGATIVE_MODE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    reg_word_t          addr;
    reg_word_t          mask;
    logic [SHIFT_W-1:0] shift;
    reg_word_t          dflt;
  } effect_rom_t;

  localparam effect_rom_t EFFECT_ROM [NUM_EFFECTS] = '{
    '{16'h002c, 16'hffff, 4'd0, 16'd4095}, '{16'h002d, 16'hff00, 4'd8, 16'd25},
    '{16'h002d, 16'h00ff, 4'd0, 16'd255},  '{16'h002e, 16'hff00, 4'd8, 16'd255},
    '{16'h002e, 16'h00ff, 4'd0, 16'd22},   '{16'h002f, 16'h00ff, 4'd0, 16'd0},
    '{16'h0042, 16'h00ff, 4'd0, 16'd128},
    '{16'h00ca, 16'hff00, 4'd8, 16'd237},  '{16'h00ce, 16'hff00, 4'd8, 16'd15},
    '{16'h00d2, 16'hff00, 4'd8, 16'd0},
    '{16'h00c9, 16'h00ff, 4'd0, 16'd68},   '{16'h00cd, 16'h00ff, 4'd0, 16'd245},
    '{16'h00d1, 16'h00ff, 4'd0, 16'd255},
    '{16'h00c9, 16'hff00, 4'd8, 16'd97},   '{16'h00cd, 16'hff00, 4'd8, 16'd230},
    '{16'h00d1, 16'hff00, 4'd8, 16'd18},
    '{16'h00ca, 16'h00ff, 4'd0, 16'd251},  '{16'h00ce, 16'h00ff, 4'd0, 16'd36},
    '{16'h00d2, 16'h00ff, 4'd0, 16'd255},
    '{16'h00c8, 16'h00ff, 4'd0, 16'd0},    '{16'h00cc, 16'h00ff, 4'd0, 16'd43},
    '{16'h00d0, 16'h00ff, 4'd0, 16'd255},
    '{16'h00cb, 16'hff00, 4'd8, 16'd255},  '{16'h00cf, 16'hff00, 4'd8, 16'd239},
    '{16'h00d3, 16'hff00, 4'd8, 16'd27},
    '{16'h00c8, 16'hff00, 4'd8, 16'd0},    '{16'h00cc, 16'hff00, 4'd8, 16'd0},
    '{16'h00d0, 16'hff00, 4'd8, 16'd0},
    '{16'h00cb, 16'h00ff, 4'd0, 16'd255},  '{16'h00cf, 16'h00ff, 4'd0, 16'd240},
    '{16'h00d3, 16'h00ff, 4'd0, 16'd240},
    '{16'h005b, 16'h00ff, 4'd0, 16'd65}
  };

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

endpackage

// ===== src/register_field_override_filter_core.sv =====
// Register field override filter: per-effect adjustment store and scan sequencer.
// Depends on rfof_pkg for the effect table and widths.
// Set transfer: the adjustment is written on acceptance. Intercept: the shared field unit takes one effect per cycle,
// the result is registered at the end of the scan, and no new item is accepted until the scan is done.
// Next item is taken while a result waits; the scan then holds until it is taken.
// Reset (rst, synchronous): adjustments zero, all effects delta mode, hooks off.
module register_field_override_filter_core
  import rfof_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic                        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [EFF_IDX_W-1:0]        effect_index,
  input  logic signed [ADJ_W-1:0]     adjust_amount,
  input  logic                        delta_mode,
  input  logic [REG_WIDTH-1:0]        reg_address,
  input  logic [REG_WIDTH-1:0]        reg_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [REG_WIDTH-1:0]        filtered_value
);

  state_t                   state;
  logic [EFF_IDX_W-1:0]     cnt;
  reg_word_t                work;
  reg_word_t                addr_q;
  logic                     register_hook;
  logic                     default_base;
  logic                     negative;
  logic signed [ADJ_W-1:0]  effect_adjust [NUM_EFFECTS];
  logic [NUM_EFFECTS-1:0]   effect_is_delta;

  logic                     accept;
  logic                     set_ok;
  effect_rom_t              set_e;
  logic signed [SUM_W-1:0]  set_amt;
  logic signed [SUM_W-1:0]  set_fmax;
  logic signed [ADJ_W-1:0]  set_clamped;

  effect_rom_t              e;
  logic signed [SUM_W-1:0]  fmax;
  reg_word_t                base;
  logic signed [SUM_W-1:0]  sum;
  reg_word_t                field;
  reg_word_t                work_next;
  logic                     hit;
  logic                     last;
  logic                     emit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last     = (cnt == EFF_IDX_W'(NUM_EFFECTS - 1));
  assign emit     = ((state == ST_SCAN && last) || state == ST_HOLD) && (!out_valid || out_ready);

  // set path: clamp to +/- field maximum
  always_comb begin
    set_ok   = (int'(effect_index) < NUM_EFFECTS);
    set_e    = EFFECT_ROM[effect_index];
    set_amt  = SUM_W'(adjust_amount);
    set_fmax = $signed(SUM_W'(set_e.mask >> set_e.shift));
    if (set_amt > set_fmax) begin
      set_clamped = ADJ_W'(set_fmax);
    end else if (set_amt < -set_fmax) begin
      set_clamped = ADJ_W'(-set_fmax);
    end else begin
      set_clamped = ADJ_W'(set_amt);
    end
  end

  // shared field unit, one effect per cycle
  always_comb begin
    e    = EFFECT_ROM[cnt];
    fmax = $signed(SUM_W'(e.mask >> e.shift));
    hit  = (register_hook || default_base) && !negative && (e.addr == addr_q);
    base = default_base ? e.dflt : ((work & e.mask) >> e.shift);
    sum  = $signed({2'b00, base});
    if (register_hook) begin
      if (effect_is_delta[cnt]) begin
        sum = $signed({2'b00, base}) + SUM_W'(effect_adjust[cnt]);
      end else begin
        sum = SUM_W'(effect_adjust[cnt]);
      end
      if (sum < 0) begin
        sum = '0;
      end else if (sum > fmax) begin
        sum = fmax;
      end
    end
    field     = REG_WIDTH'(sum);
    work_next = hit ? ((work & ~e.mask) | reg_word_t'(field << e.shift)) : work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      register_hook <= 1'b0;
      default_base  <= 1'b0;
      negative      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGISTER_HOOK: register_hook <= cfg_data;
        CFG_DEFAULT_BASE:  default_base  <= cfg_data;
        CFG_NEGATIVE_MODE: negative      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_EFFECTS; i++) begin
        effect_adjust[i] <= '0;
      end
      effect_is_delta <= '1;
    end else if (accept && (op == OP_SET) && set_ok) begin
      effect_adjust[effect_index]   <= set_clamped;
      effect_is_delta[effect_index] <= delta_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state)
        ST_IDLE: begin
          if (accept && (op == OP_INTERCEPT)) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          if (last) begin
            state <= emit ? ST_IDLE : ST_HOLD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_HOLD: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && (op == OP_INTERCEPT)) begin
      work   <= reg_value;
      addr_q <= reg_address;
    end else if (state == ST_SCAN) begin
      work <= work_next;
    end
    if (emit) begin
      filtered_value <= (state == ST_SCAN) ? work_next : work;
    end
  end

endmodule

// ===== src/rfof_checker.sv =====
// Port-level checker for register_field_override_filter_core, with its bind.
// Depends on rfof_pkg for op codes and the register width.
module rfof_checker
  import rfof_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 op,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [REG_WIDTH-1:0] filtered_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value))
    else $error("result changed while stalled");

  a_busy_after_intercept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_INTERCEPT |=> !in_ready)
    else $error("ready during effect scan");

  a_scan_length: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_INTERCEPT |=> ##30 !in_ready)
    else $error("scan ended early");

  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_SET |=> !$rose(out_valid))
    else $error("set transfer produced a result");

endmodule

bind register_field_override_filter_core rfof_checker u_rfof_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .op             (op),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .filtered_value (filtered_value)
);
